>>> src/lkv_pkg.sv
// Package for the LRU key-value store: controller states, control word,
// operation and register codes. No dependencies.
package lkv_pkg;

  localparam int CAP_W  = 5;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic FUNC_PUT = 1'b0;
  localparam logic FUNC_GET = 1'b1;

  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } lkv_state_t;

  typedef struct packed {
    logic idle;
    logic scan_clr;
    logic scan_vld;
    logic upd_vld;
    logic out_load;
  } lkv_ctrl_t;

endpackage

>>> src/lkv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

>>> src/lkv_ctrl.sv
// Sequencer of the LRU key-value store: runs the scan pass and the
// write-back pass over the entry memory. Depends on lkv_pkg.
module lkv_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_fire,
  input  logic                     out_free,
  output lkv_pkg::lkv_ctrl_t       ctrl,
  output logic [$clog2(DEPTH)-1:0] raddr,
  output logic [$clog2(DEPTH)-1:0] dat_idx
);
  import lkv_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam logic [IW:0] LAST = (IW+1)'(DEPTH);

  lkv_state_t    state_r, state_nxt;
  logic [IW:0]   cnt_r, cnt_nxt;
  logic          dvld_r;
  logic [IW-1:0] dat_idx_r;
  logic          cnt_last;

  assign cnt_last = (cnt_r == LAST);
  assign raddr    = cnt_last ? '0 : cnt_r[IW-1:0];
  assign dat_idx  = dat_idx_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_last) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (cnt_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = '0;
    case (state_r)
      ST_SCAN, ST_UPDATE: begin
        cnt_nxt = cnt_last ? '0 : cnt_r + (IW+1)'(1);
      end
      default: cnt_nxt = '0;
    endcase
  end

  always_comb begin
    ctrl.idle     = (state_r == ST_IDLE);
    ctrl.scan_clr = (state_r == ST_IDLE) && in_fire;
    ctrl.scan_vld = (state_r == ST_SCAN) && dvld_r;
    ctrl.upd_vld  = (state_r == ST_UPDATE) && dvld_r;
    ctrl.out_load = (state_r == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      dvld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dvld_r  <= ((state_r == ST_SCAN) || (state_r == ST_UPDATE)) && !cnt_last;
    end
  end

  always_ff @(posedge clk) begin
    dat_idx_r <= raddr;
  end

endmodule

>>> src/lkv_scan.sv
// Compare unit of the LRU key-value store: one entry a cycle, it tracks the
// key match, the oldest valid entry and the first free slot. Depends on lkv_pkg.
module lkv_scan #(
  parameter int DEPTH       = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lkv_pkg::lkv_ctrl_t       ctrl,
  input  logic [$clog2(DEPTH)-1:0] dat_idx,
  input  logic                     rd_vbit,
  input  logic [KEY_WIDTH-1:0]     rd_key,
  input  logic [VALUE_WIDTH-1:0]   rd_value,
  input  logic [$clog2(DEPTH)-1:0] rd_age,
  input  logic [KEY_WIDTH-1:0]     key,
  output logic                     match_found,
  output logic [$clog2(DEPTH)-1:0] match_idx,
  output logic [$clog2(DEPTH)-1:0] match_age,
  output logic [VALUE_WIDTH-1:0]   match_value,
  output logic                     old_found,
  output logic [$clog2(DEPTH)-1:0] old_idx,
  output logic [KEY_WIDTH-1:0]     old_key,
  output logic [VALUE_WIDTH-1:0]   old_value,
  output logic                     free_found,
  output logic [$clog2(DEPTH)-1:0] free_idx
);
  import lkv_pkg::*;

  localparam int IW = $clog2(DEPTH);

  logic          match_found_r, old_found_r, free_found_r;
  logic [IW-1:0] match_idx_r, match_age_r, old_idx_r, old_age_r, free_idx_r;
  logic [VALUE_WIDTH-1:0] match_value_r, old_value_r;
  logic [KEY_WIDTH-1:0]   old_key_r;
  logic          take_match, take_old, take_free;

  assign take_match = ctrl.scan_vld && rd_vbit && (rd_key == key) && !match_found_r;
  assign take_old   = ctrl.scan_vld && rd_vbit && (!old_found_r || (rd_age > old_age_r));
  assign take_free  = ctrl.scan_vld && !rd_vbit && !free_found_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.scan_clr) begin
      match_found_r <= 1'b0;
      old_found_r   <= 1'b0;
      free_found_r  <= 1'b0;
    end else begin
      if (take_match) begin
        match_found_r <= 1'b1;
      end
      if (take_old) begin
        old_found_r <= 1'b1;
      end
      if (take_free) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_match) begin
      match_idx_r   <= dat_idx;
      match_age_r   <= rd_age;
      match_value_r <= rd_value;
    end
    if (take_old) begin
      old_idx_r   <= dat_idx;
      old_age_r   <= rd_age;
      old_key_r   <= rd_key;
      old_value_r <= rd_value;
    end
    if (take_free) begin
      free_idx_r <= dat_idx;
    end
  end

  assign match_found = match_found_r;
  assign match_idx   = match_idx_r;
  assign match_age   = match_age_r;
  assign match_value = match_value_r;
  assign old_found   = old_found_r;
  assign old_idx     = old_idx_r;
  assign old_key     = old_key_r;
  assign old_value   = old_value_r;
  assign free_found  = free_found_r;
  assign free_idx    = free_idx_r;

endmodule

>>> src/lru_key_value_store.sv
// Top level of the LRU key-value store: configuration port, valid bits,
// occupancy, age update and result register. Depends on lkv_pkg, lkv_ram,
// lkv_ctrl and lkv_scan.
//
// Each word runs two passes over the single entry memory, one entry a cycle,
// and then the result is loaded. The first pass is a scan for the key, the
// oldest entry and the first free slot. The second is a write-back pass that
// updates the age ranks and, for a put, stores the new value (and, on a miss,
// the new key). The next word is taken as soon as the result is loaded, even
// while that result still waits on out_ready; a new word is not taken before
// the last one is loaded. A result that is still waiting when the next one is
// ready holds the block until out_ready.
module lru_key_value_store #(
  parameter int DEPTH       = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_func,
  input  logic [KEY_WIDTH-1:0]       in_key,
  input  logic [VALUE_WIDTH-1:0]     in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_hit,
  output logic [VALUE_WIDTH-1:0]     out_read_value,
  output logic                       out_evicted,
  output logic [KEY_WIDTH-1:0]       out_evicted_key,
  output logic [VALUE_WIDTH-1:0]     out_evicted_value,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lkv_pkg::CFG_AW-1:0] paddr,
  input  logic [lkv_pkg::CFG_DW-1:0] pwdata,
  output logic [lkv_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import lkv_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);
  localparam int XW = (OW > CAP_W) ? OW : CAP_W;
  localparam int MW = KEY_WIDTH + VALUE_WIDTH + IW;

  lkv_ctrl_t ctrl;
  logic      in_fire, out_free;

  logic [CAP_W-1:0]       cap_r;
  logic [DEPTH-1:0]       valid_r, valid_nxt;
  logic [OW-1:0]          occ_r, occ_nxt;
  logic                   func_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] value_r;

  logic                   out_valid_r, out_hit_r, out_evicted_r;
  logic [VALUE_WIDTH-1:0] out_read_value_r, out_evicted_value_r;
  logic [KEY_WIDTH-1:0]   out_evicted_key_r;

  logic [IW-1:0]          raddr, dat_idx;
  logic [MW-1:0]          rdata, wdata;
  logic [KEY_WIDTH-1:0]   rd_key, wr_key;
  logic [VALUE_WIDTH-1:0] rd_value, wr_value;
  logic [IW-1:0]          rd_age, wr_age;
  logic                   rd_vbit;

  logic                   match_found, old_found, free_found;
  logic [IW-1:0]          match_idx, match_age, old_idx, free_idx, slot;
  logic [VALUE_WIDTH-1:0] match_value, old_value;
  logic [KEY_WIDTH-1:0]   old_key;

  logic [XW-1:0]          cap_x, cap_eff;
  logic                   get_hit, put_hit, put_miss, evict;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = ctrl.idle;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? CFG_DW'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r  <= in_func;
      key_r   <= in_key;
      value_r <= in_value;
    end
  end

  lkv_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .out_free(out_free),
    .ctrl    (ctrl),
    .raddr   (raddr),
    .dat_idx (dat_idx)
  );

  lkv_ram #(
    .WIDTH(MW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ctrl.upd_vld),
    .waddr(dat_idx),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_key   = rdata[MW-1 -: KEY_WIDTH];
  assign rd_value = rdata[IW +: VALUE_WIDTH];
  assign rd_age   = rdata[IW-1:0];
  assign rd_vbit  = valid_r[dat_idx];

  lkv_scan #(
    .DEPTH      (DEPTH),
    .KEY_WIDTH  (KEY_WIDTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .dat_idx    (dat_idx),
    .rd_vbit    (rd_vbit),
    .rd_key     (rd_key),
    .rd_value   (rd_value),
    .rd_age     (rd_age),
    .key        (key_r),
    .match_found(match_found),
    .match_idx  (match_idx),
    .match_age  (match_age),
    .match_value(match_value),
    .old_found  (old_found),
    .old_idx    (old_idx),
    .old_key    (old_key),
    .old_value  (old_value),
    .free_found (free_found),
    .free_idx   (free_idx)
  );

  // A capacity of zero acts as one, and a capacity above DEPTH as DEPTH.
  assign cap_x   = XW'(cap_r);
  assign cap_eff = (cap_r == '0) ? XW'(1) :
                   ((cap_x > XW'(DEPTH)) ? XW'(DEPTH) : cap_x);

  assign get_hit  = (func_r == FUNC_GET) && match_found;
  assign put_hit  = (func_r == FUNC_PUT) && match_found;
  assign put_miss = (func_r == FUNC_PUT) && !match_found;
  assign evict    = put_miss && old_found && (XW'(occ_r) >= cap_eff);
  assign slot     = (free_found && (!evict || (free_idx < old_idx))) ? free_idx : old_idx;

  always_comb begin
    wr_key   = rd_key;
    wr_value = rd_value;
    wr_age   = rd_age;
    if (get_hit) begin
      if (rd_vbit && (rd_age > match_age)) begin
        wr_age = rd_age - IW'(1);
      end
    end else if (put_hit) begin
      if (dat_idx == match_idx) begin
        wr_value = value_r;
        wr_age   = '0;
      end else if (rd_vbit && (rd_age < match_age)) begin
        wr_age = rd_age + IW'(1);
      end
    end else if (put_miss) begin
      if (dat_idx == slot) begin
        wr_key   = key_r;
        wr_value = value_r;
        wr_age   = '0;
      end else if (rd_vbit && !(evict && (dat_idx == old_idx))) begin
        wr_age = rd_age + IW'(1);
      end
    end
  end

  assign wdata = {wr_key, wr_value, wr_age};

  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    if (get_hit) begin
      valid_nxt[match_idx] = 1'b0;
      occ_nxt              = occ_r - OW'(1);
    end else if (put_miss) begin
      if (evict) begin
        valid_nxt[old_idx] = 1'b0;
      end else begin
        occ_nxt = occ_r + OW'(1);
      end
      valid_nxt[slot] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.out_load) begin
        valid_r     <= valid_nxt;
        occ_r       <= occ_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_hit_r           <= get_hit;
      out_read_value_r    <= get_hit ? match_value : '0;
      out_evicted_r       <= evict;
      out_evicted_key_r   <= evict ? old_key : '0;
      out_evicted_value_r <= evict ? old_value : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_read_value    = out_read_value_r;
  assign out_evicted       = out_evicted_r;
  assign out_evicted_key   = out_evicted_key_r;
  assign out_evicted_value = out_evicted_value_r;

`ifndef SYNTHESIS
  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("Occupancy does not match the number of valid entries.");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(occ_r) <= DEPTH)
    else $error("Occupancy exceeds the store depth.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("A second word was taken while the first was still in work.");

  a_result_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctrl.out_load))
    else $error("A result appeared without a completed operation.");
`endif

endmodule
